### rtl/core/mctd_pkg.sv
// ----------------------------------------------------------------------------
// mctd_pkg
// Shared types and constants for the Morse key timing decoder.
// ----------------------------------------------------------------------------
package mctd_pkg;

   localparam int unsigned CHAR_W      = 14;
   localparam int unsigned TIME_W      = 32;
   localparam int unsigned DOT_W       = 16;
   localparam int unsigned CODE_W      = 8;
   localparam int unsigned COUNT_W     = 4;
   localparam int unsigned CSR_INDEX_W = 2;

   // result queue depth, and the largest number of results one item causes
   localparam int unsigned QUEUE_DEPTH   = 8;
   localparam int unsigned QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned MAX_RESULTS   = 2;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DOT_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_JAPANESE_MODE = 2'd1;

   localparam logic [DOT_W-1:0]   DOT_THRESHOLD_RESET = 16'd100;
   localparam logic [DOT_W-1:0]   DOT_LENGTH_RESET    = 16'd100;
   localparam logic [CODE_W-1:0]  CODE_MARKER         = 8'h01;
   localparam logic [COUNT_W-1:0] MAX_ELEMENTS        = 4'd8;

   localparam logic [CHAR_W-1:0] CHAR_UNKNOWN  = 14'd42;
   localparam logic [CHAR_W-1:0] CHAR_SPACE_EN = 14'd32;
   localparam logic [CHAR_W-1:0] CHAR_SPACE_JP = 14'd12288;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              is_space;
      logic              unknown_code;
      logic              last;
   } result_type;

   // results of one item, first in r0
   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } push_type;

endpackage

### rtl/core/mctd_lut.sv
// ----------------------------------------------------------------------------
// mctd_lut
// Code table: maps an element code to an English or Wabun code point.
// ----------------------------------------------------------------------------
module mctd_lut (
   input  logic [mctd_pkg::CODE_W-1:0] code,
   input  logic                        japanese_mode,
   output logic [mctd_pkg::CHAR_W-1:0] char_code,
   output logic                        unknown_code
);

   logic [mctd_pkg::CHAR_W-1:0] en_char;
   logic                        en_hit;
   logic [mctd_pkg::CHAR_W-1:0] jp_char;
   logic                        jp_hit;

   always_comb begin
      en_hit  = 1'b1;
      en_char = mctd_pkg::CHAR_UNKNOWN;
      case (code)
         8'h05: en_char = 14'd65;
         8'h18: en_char = 14'd66;
         8'h1A: en_char = 14'd67;
         8'h0C: en_char = 14'd68;
         8'h02: en_char = 14'd69;
         8'h12: en_char = 14'd70;
         8'h0E: en_char = 14'd71;
         8'h10: en_char = 14'd72;
         8'h04: en_char = 14'd73;
         8'h17: en_char = 14'd74;
         8'h0D: en_char = 14'd75;
         8'h14: en_char = 14'd76;
         8'h07: en_char = 14'd77;
         8'h06: en_char = 14'd78;
         8'h0F: en_char = 14'd79;
         8'h16: en_char = 14'd80;
         8'h1D: en_char = 14'd81;
         8'h0A: en_char = 14'd82;
         8'h08: en_char = 14'd83;
         8'h03: en_char = 14'd84;
         8'h09: en_char = 14'd85;
         8'h11: en_char = 14'd86;
         8'h0B: en_char = 14'd87;
         8'h19: en_char = 14'd88;
         8'h1B: en_char = 14'd89;
         8'h1C: en_char = 14'd90;
         8'h2F: en_char = 14'd49;
         8'h27: en_char = 14'd50;
         8'h23: en_char = 14'd51;
         8'h21: en_char = 14'd52;
         8'h20: en_char = 14'd53;
         8'h30: en_char = 14'd54;
         8'h38: en_char = 14'd55;
         8'h3C: en_char = 14'd56;
         8'h3E: en_char = 14'd57;
         8'h3F: en_char = 14'd48;
         8'h32: en_char = 14'd47;
         8'h4C: en_char = 14'd63;
         8'h73: en_char = 14'd44;
         8'h55: en_char = 14'd46;
         8'h5A: en_char = 14'd64;
         8'h36: en_char = 14'd40;
         8'h6D: en_char = 14'd41;
         default: en_hit = 1'b0;
      endcase
   end

   always_comb begin
      jp_hit  = 1'b1;
      jp_char = mctd_pkg::CHAR_UNKNOWN;
      case (code)
         8'h3B: jp_char = 14'd12450;
         8'h05: jp_char = 14'd12452;
         8'h09: jp_char = 14'd12454;
         8'h37: jp_char = 14'd12456;
         8'h28: jp_char = 14'd12458;
         8'h14: jp_char = 14'd12459;
         8'h34: jp_char = 14'd12461;
         8'h11: jp_char = 14'd12463;
         8'h1B: jp_char = 14'd12465;
         8'h1F: jp_char = 14'd12467;
         8'h35: jp_char = 14'd12469;
         8'h3A: jp_char = 14'd12471;
         8'h3D: jp_char = 14'd12473;
         8'h2E: jp_char = 14'd12475;
         8'h1E: jp_char = 14'd12477;
         8'h06: jp_char = 14'd12479;
         8'h12: jp_char = 14'd12481;
         8'h16: jp_char = 14'd12484;
         8'h2B: jp_char = 14'd12486;
         8'h24: jp_char = 14'd12488;
         8'h0A: jp_char = 14'd12490;
         8'h1A: jp_char = 14'd12491;
         8'h10: jp_char = 14'd12492;
         8'h1D: jp_char = 14'd12493;
         8'h13: jp_char = 14'd12494;
         8'h18: jp_char = 14'd12495;
         8'h39: jp_char = 14'd12498;
         8'h1C: jp_char = 14'd12501;
         8'h02: jp_char = 14'd12504;
         8'h0C: jp_char = 14'd12507;
         8'h19: jp_char = 14'd12510;
         8'h25: jp_char = 14'd12511;
         8'h03: jp_char = 14'd12512;
         8'h31: jp_char = 14'd12513;
         8'h32: jp_char = 14'd12514;
         8'h0B: jp_char = 14'd12516;
         8'h33: jp_char = 14'd12518;
         8'h07: jp_char = 14'd12520;
         8'h08: jp_char = 14'd12521;
         8'h0E: jp_char = 14'd12522;
         8'h36: jp_char = 14'd12523;
         8'h0F: jp_char = 14'd12524;
         8'h15: jp_char = 14'd12525;
         8'h0D: jp_char = 14'd12527;
         8'h17: jp_char = 14'd12530;
         8'h2A: jp_char = 14'd12531;
         8'h2D: jp_char = 14'd12540;
         8'h04: jp_char = 14'd12443;
         8'h26: jp_char = 14'd12444;
         8'h2F: jp_char = 14'd49;
         8'h27: jp_char = 14'd50;
         8'h23: jp_char = 14'd51;
         8'h21: jp_char = 14'd52;
         8'h20: jp_char = 14'd53;
         8'h30: jp_char = 14'd54;
         8'h38: jp_char = 14'd55;
         8'h3C: jp_char = 14'd56;
         8'h3E: jp_char = 14'd57;
         8'h3F: jp_char = 14'd48;
         8'h4C: jp_char = 14'd63;
         8'h55: jp_char = 14'd46;
         8'h73: jp_char = 14'd44;
         default: jp_hit = 1'b0;
      endcase
   end

   assign char_code    = japanese_mode ? jp_char : en_char;
   assign unknown_code = japanese_mode ? !jp_hit : !en_hit;

endmodule

### rtl/core/mctd_core.sv
// ----------------------------------------------------------------------------
// mctd_core
// Key timing state and per-sample decisions: classify tones, build the
// element code, emit characters and word spaces.
// ----------------------------------------------------------------------------
module mctd_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             item_valid,
   input  logic                             key_level,
   input  logic [mctd_pkg::TIME_W-1:0]      now_ms,
   input  logic [mctd_pkg::DOT_W-1:0]       dot_threshold_ms,
   input  logic                             japanese_mode,
   output mctd_pkg::push_type               push
);

   logic                           previous_level_ff, previous_level_in;
   logic [mctd_pkg::TIME_W-1:0]    tone_start_ff, tone_start_in;
   logic [mctd_pkg::TIME_W-1:0]    silence_start_ff, silence_start_in;
   logic [mctd_pkg::DOT_W-1:0]     dot_length_ff, dot_length_in;
   logic [mctd_pkg::CODE_W-1:0]    element_code_ff, element_code_in;
   logic [mctd_pkg::COUNT_W-1:0]   element_count_ff, element_count_in;
   logic                           space_pending_ff, space_pending_in;

   logic [mctd_pkg::TIME_W-1:0]    tone_ms;
   logic [mctd_pkg::TIME_W-1:0]    quiet_ms;
   logic [mctd_pkg::DOT_W+1:0]     dot3_ms;
   logic [mctd_pkg::DOT_W+2:0]     dot7_ms;
   logic                           rise, fall, steady_high;
   logic                           is_dash;
   logic [mctd_pkg::COUNT_W-1:0]   count_inc;
   logic                           emit_char, emit_space;
   logic [mctd_pkg::CHAR_W-1:0]    lut_char;
   logic                           lut_unknown;
   mctd_pkg::result_type           char_res, space_res;

   mctd_lut u_lut (
      .code          (element_code_ff),
      .japanese_mode (japanese_mode),
      .char_code     (lut_char),
      .unknown_code  (lut_unknown)
   );

   assign tone_ms  = now_ms - tone_start_ff;
   assign quiet_ms = now_ms - silence_start_ff;
   assign dot3_ms  = ({2'b00, dot_length_ff} << 1) + {2'b00, dot_length_ff};
   assign dot7_ms  = ({3'b000, dot_length_ff} << 3) - {3'b000, dot_length_ff};

   assign rise        = item_valid &&  key_level && !previous_level_ff;
   assign fall        = item_valid && !key_level &&  previous_level_ff;
   assign steady_high = item_valid &&  key_level &&  previous_level_ff;

   assign is_dash   = !(tone_ms < {16'd0, dot_threshold_ms});
   assign count_inc = element_count_ff + 4'd1;

   assign emit_char  = steady_high && (element_count_ff != '0)
                       && (quiet_ms > {14'd0, dot3_ms});
   assign emit_space = steady_high && (emit_char || space_pending_ff)
                       && (quiet_ms > {13'd0, dot7_ms});

   always_comb begin
      previous_level_in = previous_level_ff;
      tone_start_in     = tone_start_ff;
      silence_start_in  = silence_start_ff;
      dot_length_in     = dot_length_ff;
      element_code_in   = element_code_ff;
      element_count_in  = element_count_ff;
      space_pending_in  = space_pending_ff;

      if (item_valid) begin
         previous_level_in = key_level;
      end
      if (rise) begin
         silence_start_in = now_ms;
         if (!is_dash) begin
            dot_length_in = tone_ms[mctd_pkg::DOT_W-1:0];
         end
         // too many elements: drop the partial code
         if (count_inc > mctd_pkg::MAX_ELEMENTS) begin
            element_code_in  = mctd_pkg::CODE_MARKER;
            element_count_in = '0;
         end else begin
            element_code_in  = {element_code_ff[mctd_pkg::CODE_W-2:0], is_dash};
            element_count_in = count_inc;
         end
      end
      if (fall) begin
         tone_start_in = now_ms;
      end
      if (emit_char) begin
         element_code_in  = mctd_pkg::CODE_MARKER;
         element_count_in = '0;
         space_pending_in = 1'b1;
      end
      if (emit_space) begin
         space_pending_in = 1'b0;
      end
   end

   always_comb begin
      char_res.char_code    = lut_char;
      char_res.is_space     = 1'b0;
      char_res.unknown_code = lut_unknown;
      char_res.last         = !emit_space;

      space_res.char_code    = japanese_mode ? mctd_pkg::CHAR_SPACE_JP
                                             : mctd_pkg::CHAR_SPACE_EN;
      space_res.is_space     = 1'b1;
      space_res.unknown_code = 1'b0;
      space_res.last         = 1'b1;

      push.count = {1'b0, emit_char} + {1'b0, emit_space};
      push.r0    = emit_char ? char_res : space_res;
      push.r1    = space_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_level_ff <= 1'b1;
         tone_start_ff     <= '0;
         silence_start_ff  <= '0;
         dot_length_ff     <= mctd_pkg::DOT_LENGTH_RESET;
         element_code_ff   <= mctd_pkg::CODE_MARKER;
         element_count_ff  <= '0;
         space_pending_ff  <= 1'b0;
      end else begin
         previous_level_ff <= previous_level_in;
         tone_start_ff     <= tone_start_in;
         silence_start_ff  <= silence_start_in;
         dot_length_ff     <= dot_length_in;
         element_code_ff   <= element_code_in;
         element_count_ff  <= element_count_in;
         space_pending_ff  <= space_pending_in;
      end
   end

endmodule

### rtl/core/mctd_fifo.sv
// ----------------------------------------------------------------------------
// mctd_fifo
// Result queue: takes up to two results a cycle, hands out one per cycle while popped.
// ----------------------------------------------------------------------------
module mctd_fifo (
   input  logic                               clock,
   input  logic                               reset,
   input  mctd_pkg::push_type                 push,
   input  logic                               pop,
   output logic                               out_valid,
   output mctd_pkg::result_type               out_data,
   output logic [mctd_pkg::QUEUE_CNT_W-1:0]   count
);

   mctd_pkg::result_type                 entry_ff [mctd_pkg::QUEUE_DEPTH];
   logic [mctd_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [mctd_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [mctd_pkg::QUEUE_CNT_W-1:0]     count_ff, count_in;
   logic [mctd_pkg::QUEUE_PTR_W-1:0]     wr_ptr_next;
   logic [mctd_pkg::QUEUE_PTR_W-1:0]     ptr_one;
   logic                                 do_pop;

   assign ptr_one     = {{(mctd_pkg::QUEUE_PTR_W-1){1'b0}}, 1'b1};
   assign out_valid   = (count_ff != '0);
   assign out_data    = entry_ff[rd_ptr_ff];
   assign count       = count_ff;
   assign do_pop      = pop && out_valid;
   assign wr_ptr_next = wr_ptr_ff + ptr_one;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + {{(mctd_pkg::QUEUE_PTR_W-2){1'b0}}, push.count};
      rd_ptr_in = do_pop ? rd_ptr_ff + ptr_one : rd_ptr_ff;
      count_in  = count_ff + {{(mctd_pkg::QUEUE_CNT_W-2){1'b0}}, push.count}
                  - {{(mctd_pkg::QUEUE_CNT_W-1){1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.r0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.r1;
      end
   end

endmodule

### rtl/core/morse_code_timing_decoder.sv
// ----------------------------------------------------------------------------
// morse_code_timing_decoder
// Decodes timestamped Morse key samples into English or Wabun characters
// and word spaces.
// ----------------------------------------------------------------------------
// Each accepted sample (key_level low = tone, now_ms = timestamp) lands in an
// input register; in the following cycle the decode logic updates the key
// timing state and pushes zero, one or two results (character, then word
// space) into an eight-entry result queue that drives the rsp_ port. A
// sample is accepted every cycle as long as the queue has room for the
// worst case of the sample in flight plus the new one: req_stall rises when
// queue occupancy plus two for an occupied input register exceeds six.
// Samples that cause no result therefore flow at one per cycle, and the
// first result of a sample passes the input register and is written into
// the result queue before it is shown on rsp_. A
// result is shown on rsp_ until taken; req_ and rsp_ never wait on each
// other combinationally. Configuration writes are always taken (csr_ready
// is tied high) and must only happen while the block is idle; writes to an
// unknown index are dropped.
// ----------------------------------------------------------------------------
module morse_code_timing_decoder (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_key_level,
   input  logic [mctd_pkg::TIME_W-1:0]          req_now_ms,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mctd_pkg::CHAR_W-1:0]          rsp_char_code,
   output logic                                 rsp_is_space,
   output logic                                 rsp_unknown_code,
   output logic                                 rsp_last,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mctd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mctd_pkg::DOT_W-1:0]           csr_wdata
);

   // configuration registers
   logic [mctd_pkg::DOT_W-1:0]         dot_threshold_ff;
   logic                               japanese_mode_ff;

   // input register
   logic                               stg_valid_ff, stg_valid_in;
   logic                               stg_level_ff;
   logic [mctd_pkg::TIME_W-1:0]        stg_now_ff;

   logic                               req_accept;
   logic                               rsp_accept;
   logic                               csr_write;
   mctd_pkg::push_type                 push;
   mctd_pkg::result_type               head;
   logic [mctd_pkg::QUEUE_CNT_W-1:0]   queue_count;
   logic [mctd_pkg::QUEUE_CNT_W:0]     queue_need;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;

   // reserve room for the sample in the input register and the new one
   assign queue_need = {1'b0, queue_count}
                       + (stg_valid_ff ? (mctd_pkg::QUEUE_CNT_W+1)'(mctd_pkg::MAX_RESULTS)
                                       : '0);
   assign req_stall  = queue_need >
                       (mctd_pkg::QUEUE_CNT_W+1)'(mctd_pkg::QUEUE_DEPTH
                                                   - mctd_pkg::MAX_RESULTS);

   assign stg_valid_in = req_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_threshold_ff <= mctd_pkg::DOT_THRESHOLD_RESET;
         japanese_mode_ff <= 1'b0;
         stg_valid_ff     <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         if (csr_write) begin
            case (csr_index)
               mctd_pkg::CSR_DOT_THRESHOLD: dot_threshold_ff <= csr_wdata;
               mctd_pkg::CSR_JAPANESE_MODE: japanese_mode_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   // hold the payload when nothing is taken
   always_ff @(posedge clock) begin
      if (req_accept) begin
         stg_level_ff <= req_key_level;
         stg_now_ff   <= req_now_ms;
      end
   end

   mctd_core u_core (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (stg_valid_ff),
      .key_level        (stg_level_ff),
      .now_ms           (stg_now_ff),
      .dot_threshold_ms (dot_threshold_ff),
      .japanese_mode    (japanese_mode_ff),
      .push             (push)
   );

   mctd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_accept),
      .out_valid (rsp_valid),
      .out_data  (head),
      .count     (queue_count)
   );

   assign rsp_char_code    = head.char_code;
   assign rsp_is_space     = head.is_space;
   assign rsp_unknown_code = head.unknown_code;
   assign rsp_last         = head.last;

   // queue never overflows
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      queue_count <= mctd_pkg::QUEUE_CNT_W'(mctd_pkg::QUEUE_DEPTH))
      else $error("result queue overflow");

   // a double push is a character followed by the closing word space
   a_double_push: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> !push.r0.is_space && !push.r0.last
                             && push.r1.is_space && push.r1.last)
      else $error("bad result pair");

   // results only come from a sample in the input register
   a_push_source: assert property (@(posedge clock) disable iff (reset)
      !stg_valid_ff |-> push.count == 2'd0)
      else $error("result without a sample");

   // nothing to show right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result queue not empty after reset");

endmodule

### sim/tb_morse_code_timing_decoder.sv
// ----------------------------------------------------------------------------
// tb_morse_code_timing_decoder
// Self-checking bench for the Morse key timing decoder: timed key samples
// in, decoded characters and word spaces out, each compared in order with
// a cycle-free prediction of the decoder kept inside the bench.
// ----------------------------------------------------------------------------
module tb_morse_code_timing_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   // key line levels: low is tone, high is silence
   localparam logic KEY_TONE    = 1'b0;
   localparam logic KEY_SILENCE = 1'b1;

   // register indexes that the block must drop
   localparam logic [mctd_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_2 = 2'd2;
   localparam logic [mctd_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_3 = 2'd3;

   localparam int unsigned SEGMENTS         = 8;
   localparam int unsigned SEGMENT_ITEMS    = 75;
   localparam int unsigned DRAIN_CYCLES     = 8;    // input register plus queue push
   localparam int unsigned LONG_HOLD_CYCLES = 400;
   localparam int unsigned FLUSH_GAP_MS     = 600000; // beyond 7 x the largest dot

   typedef struct packed {
      logic                        level;
      logic [mctd_pkg::TIME_W-1:0] stamp;
   } key_sample_type;

   // how a generated character is closed off by later silence samples
   typedef enum int {
      END_NONE,   // no closing sample, next character runs on
      END_CHAR,   // character, and the word space too at the top of its range
      END_SPLIT,  // character, then the word space in a later sample
      END_BOTH,   // character and word space from one sample
      END_EDGE    // samples exactly at 3 and 7 dot lengths, then one past
   } char_ending_type;

   logic                             clock;
   logic                             reset     = 1'b1;

   logic                             req_valid     = 1'b0;
   logic                             req_stall;
   logic                             req_key_level = KEY_SILENCE;
   logic [mctd_pkg::TIME_W-1:0]      req_now_ms    = '0;

   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [mctd_pkg::CHAR_W-1:0]      rsp_char_code;
   logic                             rsp_is_space;
   logic                             rsp_unknown_code;
   logic                             rsp_last;

   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [mctd_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [mctd_pkg::DOT_W-1:0]       csr_wdata = '0;

   morse_code_timing_decoder uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_key_level    (req_key_level),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_char_code    (rsp_char_code),
      .rsp_is_space     (rsp_is_space),
      .rsp_unknown_code (rsp_unknown_code),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // Register copies, changed only while the decoder is idle
   // ------------------------------------------------------------------------
   logic [mctd_pkg::DOT_W-1:0] dot_threshold_cfg = mctd_pkg::DOT_THRESHOLD_RESET;
   logic                       wabun_cfg         = 1'b0;

   // ------------------------------------------------------------------------
   // Decoder state as the bench predicts it
   // ------------------------------------------------------------------------
   logic                         key_was_high     = 1'b1;
   logic [mctd_pkg::TIME_W-1:0]  tone_began_ms    = '0;
   logic [mctd_pkg::TIME_W-1:0]  quiet_began_ms   = '0;
   logic [mctd_pkg::DOT_W-1:0]   dot_len_ms       = mctd_pkg::DOT_LENGTH_RESET;
   logic [mctd_pkg::CODE_W-1:0]  element_bits     = mctd_pkg::CODE_MARKER;
   logic [mctd_pkg::COUNT_W-1:0] element_total    = '0;
   logic                         word_gap_pending = 1'b0;

   key_sample_type       pending_samples[$];   // samples waiting to be offered
   mctd_pkg::result_type expected_chars[$];    // predicted results, oldest first

   // generator's view of the line, used to place samples around dot lengths
   logic [mctd_pkg::TIME_W-1:0] gen_ms      = '0;
   logic                        gen_level   = KEY_SILENCE;
   logic [mctd_pkg::TIME_W-1:0] gen_tone_ms = '0;
   int unsigned                 gen_dot     = mctd_pkg::DOT_LENGTH_RESET;

   int unsigned samples_queued      = 0;
   int unsigned samples_accepted    = 0;
   int unsigned chars_checked       = 0;
   int unsigned unknown_checked     = 0;
   int unsigned spaces_checked      = 0;
   int unsigned input_stall_cycles  = 0;
   int unsigned csr_writes          = 0;
   int unsigned error_count         = 0;
   int unsigned send_idle_pct       = 0;
   int unsigned recv_stall_pct      = 0;
   int unsigned long_holds_asked    = 0;

   // ------------------------------------------------------------------------
   // Character tables: element code with marker bit -> code point
   // ------------------------------------------------------------------------
   function automatic mctd_pkg::result_type decode_element_bits(
      input logic [mctd_pkg::CODE_W-1:0] bits);
      mctd_pkg::result_type r;
      r = '0;
      if (!wabun_cfg) begin
         case (bits)
            8'h05: r.char_code = 14'("A");  8'h18: r.char_code = 14'("B");
            8'h1A: r.char_code = 14'("C");  8'h0C: r.char_code = 14'("D");
            8'h02: r.char_code = 14'("E");  8'h12: r.char_code = 14'("F");
            8'h0E: r.char_code = 14'("G");  8'h10: r.char_code = 14'("H");
            8'h04: r.char_code = 14'("I");  8'h17: r.char_code = 14'("J");
            8'h0D: r.char_code = 14'("K");  8'h14: r.char_code = 14'("L");
            8'h07: r.char_code = 14'("M");  8'h06: r.char_code = 14'("N");
            8'h0F: r.char_code = 14'("O");  8'h16: r.char_code = 14'("P");
            8'h1D: r.char_code = 14'("Q");  8'h0A: r.char_code = 14'("R");
            8'h08: r.char_code = 14'("S");  8'h03: r.char_code = 14'("T");
            8'h09: r.char_code = 14'("U");  8'h11: r.char_code = 14'("V");
            8'h0B: r.char_code = 14'("W");  8'h19: r.char_code = 14'("X");
            8'h1B: r.char_code = 14'("Y");  8'h1C: r.char_code = 14'("Z");
            8'h2F: r.char_code = 14'("1");  8'h27: r.char_code = 14'("2");
            8'h23: r.char_code = 14'("3");  8'h21: r.char_code = 14'("4");
            8'h20: r.char_code = 14'("5");  8'h30: r.char_code = 14'("6");
            8'h38: r.char_code = 14'("7");  8'h3C: r.char_code = 14'("8");
            8'h3E: r.char_code = 14'("9");  8'h3F: r.char_code = 14'("0");
            8'h32: r.char_code = 14'("/");  8'h4C: r.char_code = 14'("?");
            8'h73: r.char_code = 14'(",");  8'h55: r.char_code = 14'(".");
            8'h5A: r.char_code = 14'("@");  8'h36: r.char_code = 14'("(");
            8'h6D: r.char_code = 14'(")");
            default: begin
               r.char_code    = mctd_pkg::CHAR_UNKNOWN;
               r.unknown_code = 1'b1;
            end
         endcase
      end else begin
         case (bits)
            8'h3B: r.char_code = 14'd12450;  8'h05: r.char_code = 14'd12452;
            8'h09: r.char_code = 14'd12454;  8'h37: r.char_code = 14'd12456;
            8'h28: r.char_code = 14'd12458;  8'h14: r.char_code = 14'd12459;
            8'h34: r.char_code = 14'd12461;  8'h11: r.char_code = 14'd12463;
            8'h1B: r.char_code = 14'd12465;  8'h1F: r.char_code = 14'd12467;
            8'h35: r.char_code = 14'd12469;  8'h3A: r.char_code = 14'd12471;
            8'h3D: r.char_code = 14'd12473;  8'h2E: r.char_code = 14'd12475;
            8'h1E: r.char_code = 14'd12477;  8'h06: r.char_code = 14'd12479;
            8'h12: r.char_code = 14'd12481;  8'h16: r.char_code = 14'd12484;
            8'h2B: r.char_code = 14'd12486;  8'h24: r.char_code = 14'd12488;
            8'h0A: r.char_code = 14'd12490;  8'h1A: r.char_code = 14'd12491;
            8'h10: r.char_code = 14'd12492;  8'h1D: r.char_code = 14'd12493;
            8'h13: r.char_code = 14'd12494;  8'h18: r.char_code = 14'd12495;
            8'h39: r.char_code = 14'd12498;  8'h1C: r.char_code = 14'd12501;
            8'h02: r.char_code = 14'd12504;  8'h0C: r.char_code = 14'd12507;
            8'h19: r.char_code = 14'd12510;  8'h25: r.char_code = 14'd12511;
            8'h03: r.char_code = 14'd12512;  8'h31: r.char_code = 14'd12513;
            8'h32: r.char_code = 14'd12514;  8'h0B: r.char_code = 14'd12516;
            8'h33: r.char_code = 14'd12518;  8'h07: r.char_code = 14'd12520;
            8'h08: r.char_code = 14'd12521;  8'h0E: r.char_code = 14'd12522;
            8'h36: r.char_code = 14'd12523;  8'h0F: r.char_code = 14'd12524;
            8'h15: r.char_code = 14'd12525;  8'h0D: r.char_code = 14'd12527;
            8'h17: r.char_code = 14'd12530;  8'h2A: r.char_code = 14'd12531;
            8'h2D: r.char_code = 14'd12540;  8'h04: r.char_code = 14'd12443;
            8'h26: r.char_code = 14'd12444;
            8'h2F: r.char_code = 14'("1");  8'h27: r.char_code = 14'("2");
            8'h23: r.char_code = 14'("3");  8'h21: r.char_code = 14'("4");
            8'h20: r.char_code = 14'("5");  8'h30: r.char_code = 14'("6");
            8'h38: r.char_code = 14'("7");  8'h3C: r.char_code = 14'("8");
            8'h3E: r.char_code = 14'("9");  8'h3F: r.char_code = 14'("0");
            8'h4C: r.char_code = 14'("?");  8'h55: r.char_code = 14'(".");
            8'h73: r.char_code = 14'(",");
            default: begin
               r.char_code    = mctd_pkg::CHAR_UNKNOWN;
               r.unknown_code = 1'b1;
            end
         endcase
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Advance the predicted decoder by one accepted sample and queue the
   // results it causes: a character first, then a word space.
   // ------------------------------------------------------------------------
   task automatic predict_sample(input logic level,
                                 input logic [mctd_pkg::TIME_W-1:0] stamp);
      logic [mctd_pkg::TIME_W-1:0] span;
      mctd_pkg::result_type        found[2];
      int                          n;
      n = 0;
      // tone ends: classify it and shift the element in
      if (level == KEY_SILENCE && key_was_high == KEY_TONE) begin
         span           = stamp - tone_began_ms;
         quiet_began_ms = stamp;
         element_bits   = {element_bits[mctd_pkg::CODE_W-2:0],
                           span >= {16'b0, dot_threshold_cfg}};
         if (span < {16'b0, dot_threshold_cfg})
            dot_len_ms = span[mctd_pkg::DOT_W-1:0];
         element_total = element_total + 4'd1;
         // too many elements: drop the code and start over
         if (element_total > mctd_pkg::MAX_ELEMENTS) begin
            element_bits  = mctd_pkg::CODE_MARKER;
            element_total = '0;
         end
      end
      if (level == KEY_TONE && key_was_high == KEY_SILENCE)
         tone_began_ms = stamp;
      // silence goes on: the character gap, then the word gap
      if (level == KEY_SILENCE && key_was_high == KEY_SILENCE) begin
         span = stamp - quiet_began_ms;
         if (element_total != 0 && span > 3 * {16'b0, dot_len_ms}) begin
            found[n]         = decode_element_bits(element_bits);
            n++;
            element_bits     = mctd_pkg::CODE_MARKER;
            element_total    = '0;
            word_gap_pending = 1'b1;
         end
         if (word_gap_pending && span > 7 * {16'b0, dot_len_ms}) begin
            found[n]           = '0;
            found[n].char_code = wabun_cfg ? mctd_pkg::CHAR_SPACE_JP
                                           : mctd_pkg::CHAR_SPACE_EN;
            found[n].is_space  = 1'b1;
            n++;
            word_gap_pending   = 1'b0;
         end
      end
      key_was_high = level;
      for (int i = 0; i < n; i++) begin
         found[i].last = (i == n - 1);
         expected_chars.push_back(found[i]);
      end
   endtask

   // ------------------------------------------------------------------------
   // Clock, and a hard stop in case the decoder hangs
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // about 620 samples finish well within this 2 ms limit even with every stall
   initial begin
      #2ms;
      $display("Simulation FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Sample driver: offer the next queued item when the slot is free, hold
   // it untouched while stalled, predict at the accepting edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : sample_driver
      key_sample_type next_sample;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_sample(req_key_level, req_now_ms);
            samples_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_sample   = pending_samples.pop_front();
               req_valid     <= 1'b1;
               req_key_level <= next_sample.level;
               req_now_ms    <= next_sample.stamp;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver stall: random per phase, or a long hold-off when one is asked
   // for, counted down here so the sender keeps pushing meanwhile.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : result_stall
      int unsigned holds_served;
      int unsigned hold_left;
      if (reset) begin
         rsp_stall    <= 1'b0;
         holds_served = 0;
         hold_left    = 0;
      end else if (holds_served != long_holds_asked) begin
         holds_served = long_holds_asked;
         hold_left    = LONG_HOLD_CYCLES;
         rsp_stall    <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor: compare each taken item with the oldest prediction
   // ------------------------------------------------------------------------
   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : result_monitor
      mctd_pkg::result_type want;
      if (!reset) begin
         if (req_valid && req_stall)
            input_stall_cycles++;
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               $error("char_code: expected no result, got %0d", rsp_char_code);
               error_count++;
            end else begin
               want = expected_chars.pop_front();
               compare_field("char_code", want.char_code, rsp_char_code);
               compare_field("is_space", want.is_space, rsp_is_space);
               compare_field("unknown_code", want.unknown_code, rsp_unknown_code);
               compare_field("last", want.last, rsp_last);
               if (want.is_space)
                  spaces_checked++;
               else
                  chars_checked++;
               if (want.unknown_code)
                  unknown_checked++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // queue one item and track the dot length the decoder will hold after it
   task automatic add_sample(input logic level, input logic [mctd_pkg::TIME_W-1:0] stamp);
      key_sample_type              s;
      logic [mctd_pkg::TIME_W-1:0] span;
      span = stamp - gen_tone_ms;
      if (level == KEY_SILENCE && gen_level == KEY_TONE && span < {16'b0, dot_threshold_cfg})
         gen_dot = span;
      if (level == KEY_TONE && gen_level == KEY_SILENCE)
         gen_tone_ms = stamp;
      gen_level = level;
      s.level   = level;
      s.stamp   = stamp;
      pending_samples.push_back(s);
      samples_queued++;
   endtask

   // key one character, first element from the top of the pattern
   task automatic add_character(input int unsigned n_el, input logic [9:0] pattern,
                                input int unsigned dot_ms, input int unsigned dash_ms,
                                input char_ending_type ending);
      int unsigned                 tone;
      logic [mctd_pkg::TIME_W-1:0] quiet_from;
      quiet_from = gen_ms;
      for (int i = n_el; i > 0; i--) begin
         tone = pattern[i-1] ? dash_ms : dot_ms;
         add_sample(KEY_TONE, gen_ms);
         if ($urandom_range(3) == 0)
            add_sample(KEY_TONE, gen_ms + tone / 2);
         gen_ms += tone;
         add_sample(KEY_SILENCE, gen_ms);
         quiet_from = gen_ms;
         // a silence sample inside the element gap must not end the character
         if (gen_dot != 0 && $urandom_range(3) == 0)
            add_sample(KEY_SILENCE, gen_ms + $urandom_range(3 * gen_dot));
         gen_ms += $urandom_range(1, 3 * gen_dot + 1);
      end
      case (ending)
         END_CHAR: begin
            add_sample(KEY_SILENCE, quiet_from + 3 * gen_dot + 1 + $urandom_range(4 * gen_dot));
         end
         END_SPLIT: begin
            add_sample(KEY_SILENCE, quiet_from + 3 * gen_dot + 1);
            add_sample(KEY_SILENCE, quiet_from + 7 * gen_dot + 1 + $urandom_range(50));
         end
         END_BOTH: begin
            add_sample(KEY_SILENCE, quiet_from + 7 * gen_dot + 1 + $urandom_range(3 * gen_dot));
         end
         END_EDGE: begin
            add_sample(KEY_SILENCE, quiet_from + 3 * gen_dot);
            add_sample(KEY_SILENCE, quiet_from + 7 * gen_dot);
            add_sample(KEY_SILENCE, quiet_from + 7 * gen_dot + 1);
         end
         default: ;
      endcase
      if (ending != END_NONE)
         gen_ms = quiet_from + 7 * gen_dot + 60 + $urandom_range(100);
   endtask

   // a few random samples, then silence long enough to flush the decoder
   task automatic add_noise();
      int unsigned n;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(2) == 0)
            gen_ms = $urandom;
         else
            gen_ms += $urandom_range(1000);
         add_sample(1'($urandom_range(1)), gen_ms);
      end
      add_sample(KEY_SILENCE, gen_ms);
      gen_ms += FLUSH_GAP_MS;
      add_sample(KEY_SILENCE, gen_ms);
      gen_ms += 5;
   endtask

   // mostly well-formed characters with random content, some noise
   task automatic queue_traffic(input int unsigned count);
      int unsigned     goal, n_el, dot_ms, dash_ms, pick;
      char_ending_type ending;
      goal = samples_queued + count;
      while (samples_queued < goal) begin
         if ($urandom_range(99) < 80) begin
            pick = $urandom_range(99);
            if (pick < 85)      n_el = $urandom_range(1, 6);
            else if (pick < 93) n_el = $urandom_range(7, 8);
            else                n_el = $urandom_range(9, 10);
            // dot and dash on either side of the threshold, sometimes right at it
            if (dot_threshold_cfg == 0)
               dot_ms = $urandom_range(1, 60);
            else if ($urandom_range(9) == 0)
               dot_ms = dot_threshold_cfg - 1;
            else
               dot_ms = $urandom_range(dot_threshold_cfg / 4, dot_threshold_cfg - 1);
            if ($urandom_range(9) == 0)
               dash_ms = dot_threshold_cfg;
            else
               dash_ms = dot_threshold_cfg + $urandom_range(dot_threshold_cfg + 50);
            case ($urandom_range(9))
               0:       ending = END_NONE;
               1, 2, 3: ending = END_CHAR;
               4, 5, 6: ending = END_SPLIT;
               7, 8:    ending = END_BOTH;
               default: ending = END_EDGE;
            endcase
            add_character(n_el, 10'($urandom), dot_ms, dash_ms, ending);
         end else begin
            add_noise();
         end
      end
   endtask

   // wait until every queued item is taken and every result checked
   task automatic wait_drained();
      while (samples_accepted != samples_queued || expected_chars.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one register write; call right after a rising edge
   task automatic write_register(input logic [mctd_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [mctd_pkg::DOT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (index == mctd_pkg::CSR_DOT_THRESHOLD)
         dot_threshold_cfg = value;
      else if (index == mctd_pkg::CSR_JAPANESE_MODE)
         wabun_cfg = value[0];
      csr_writes++;
      @(posedge clock);
   endtask

   // threshold extremes, both tables, dropped indexes and high value bits
   task automatic configure_segment(input int unsigned seg);
      case (seg)
         0: begin
            write_register(mctd_pkg::CSR_DOT_THRESHOLD, mctd_pkg::DOT_THRESHOLD_RESET);
            write_register(mctd_pkg::CSR_JAPANESE_MODE, 16'd0);
            write_register(CSR_UNUSED_2, 16'd7);
         end
         1: begin
            // no tone is short enough: dashes only
            write_register(mctd_pkg::CSR_DOT_THRESHOLD, 16'd0);
            write_register(mctd_pkg::CSR_JAPANESE_MODE, 16'd1);
         end
         2: begin
            write_register(mctd_pkg::CSR_DOT_THRESHOLD, 16'hFFFF);
            write_register(mctd_pkg::CSR_JAPANESE_MODE, 16'd0);
         end
         3: begin
            // dots of zero length: any silence ends the character
            write_register(mctd_pkg::CSR_DOT_THRESHOLD, 16'd1);
            write_register(mctd_pkg::CSR_JAPANESE_MODE, 16'hFFFF);
         end
         4: begin
            write_register(mctd_pkg::CSR_DOT_THRESHOLD, 16'($urandom_range(20, 300)));
            write_register(mctd_pkg::CSR_JAPANESE_MODE, 16'hFFFE);
         end
         5: begin
            write_register(mctd_pkg::CSR_DOT_THRESHOLD, 16'($urandom_range(1, 65535)));
            write_register(mctd_pkg::CSR_JAPANESE_MODE, 16'd1);
            write_register(CSR_UNUSED_3, 16'hFFFF);
         end
         6: begin
            write_register(mctd_pkg::CSR_DOT_THRESHOLD, 16'($urandom_range(2, 60)));
            write_register(mctd_pkg::CSR_JAPANESE_MODE, 16'd0);
         end
         default: begin
            write_register(mctd_pkg::CSR_DOT_THRESHOLD, 16'($urandom_range(60, 2000)));
            write_register(mctd_pkg::CSR_JAPANESE_MODE, 16'd1);
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part, reset settings (threshold 100, English table).
      // A silence sample with nothing keyed yet: no result.
      add_sample(KEY_SILENCE, 32'h0000_0000);
      // Start just below the wrap of the timestamp so differences wrap.
      gen_ms = 32'hFFFF_FFC0;
      add_character(1, 10'b0, 50, 150, END_SPLIT);      // dot: E, then space
      add_character(1, 10'b1, 50, 150, END_EDGE);       // dash at gap edges: T
      add_character(6, 10'b0, 50, 150, END_BOTH);       // six dots: unknown
      // one-millisecond tone across the wrap: dot length 1
      add_sample(KEY_TONE, 32'hFFFF_FFFF);
      add_sample(KEY_SILENCE, 32'h0000_0000);
      add_sample(KEY_SILENCE, 32'h0000_0010);
      gen_ms = 32'h0000_0100;
      wait_drained();

      // Random part: each segment picks new settings and an idle pattern,
      // and pauses the sender halfway until every result is in.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         configure_segment(seg);
         case (seg % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
         endcase
         // long receiver hold-off with a busy sender: fill the result queue
         if (seg == 4)
            long_holds_asked++;
         if (seg == 5)
            gen_ms = 32'hFFFF_FFFF - $urandom_range(200000);
         queue_traffic(SEGMENT_ITEMS / 2);
         wait_drained();
         queue_traffic(SEGMENT_ITEMS - SEGMENT_ITEMS / 2);
         wait_drained();
      end

      $display("Run covered %0d key samples under %0d register writes across %0d settings.",
               samples_accepted, csr_writes, SEGMENTS);
      $display("Checked %0d characters (%0d unknown) and %0d word spaces; input stalled %0d cycles.",
               chars_checked, unknown_checked, spaces_checked, input_stall_cycles);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/mctd_pkg.sv
rtl/core/mctd_lut.sv
rtl/core/mctd_core.sv
rtl/core/mctd_fifo.sv
rtl/core/morse_code_timing_decoder.sv
sim/tb_morse_code_timing_decoder.sv
